// ===== rtl/ple_pkg.sv =====
package ple_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned OP_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned ST_W    = 2;

  // Default list depth
  localparam int unsigned CAPACITY_DEF = 16;

  // Operation codes carried by an input item
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Broadcast command seen by every cell of the row
  typedef enum logic [1:0] {
    CK_HOLD = 2'd0,
    CK_INS  = 2'd1,
    CK_DEL  = 2'd2
  } cell_kind_t;

endpackage

// ===== rtl/ple_cell.sv =====
module ple_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                                clk,
  input  ple_pkg::cell_kind_t                 cmd_kind,
  input  logic [IDX_W-1:0]                    cmd_idx,
  input  logic signed [ple_pkg::VALUE_W-1:0]  ins_value,
  input  logic signed [ple_pkg::VALUE_W-1:0]  left_val,
  input  logic signed [ple_pkg::VALUE_W-1:0]  right_val,
  input  logic [CNT_W-1:0]                    count,
  output logic signed [ple_pkg::VALUE_W-1:0]  val,
  output logic signed [ple_pkg::VALUE_W-1:0]  tap
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_POS1 = CNT_W'(IDX + 1);

  logic signed [ple_pkg::VALUE_W-1:0] val_r;
  logic signed [ple_pkg::VALUE_W-1:0] val_nxt;

  // Shift, load or hold on a compare of this cell's place against the index
  always_comb begin
    val_nxt = val_r;
    case (cmd_kind)
      ple_pkg::CK_INS: begin
        if (MY_IDX == cmd_idx) begin
          val_nxt = ins_value;
        end else if (MY_IDX > cmd_idx) begin
          val_nxt = left_val;
        end
      end
      ple_pkg::CK_DEL: begin
        if (MY_IDX >= cmd_idx) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

  // Only the last held cell drives its tap
  assign tap = (count == MY_POS1) ? val_r : '0;

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// An accepted item's result is held pending and is loaded into the output registers
// once they are free; a stalled output result delays the load.
// A new item is not taken while a result is pending; the cell row is updated at the
// accepting edge and read back for the front and back values when the result is loaded.
// A stalled result holds off the next result's load, and so later items, until it is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// cell contents are not cleared.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ple_pkg::OP_W-1:0]            in_operation,
  input  logic signed [ple_pkg::VALUE_W-1:0]  in_value,
  input  logic [ple_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ple_pkg::ST_W-1:0]            out_status,
  output logic [CNT_W-1:0]                    out_count,
  output logic signed [ple_pkg::VALUE_W-1:0]  out_front_value,
  output logic signed [ple_pkg::VALUE_W-1:0]  out_back_value
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W =
    ((ple_pkg::POS_W > CNT_W) ? ple_pkg::POS_W : CNT_W) + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    pend_r;
  logic [ple_pkg::ST_W-1:0] pend_status_r;
  logic                    out_valid_r;
  logic [ple_pkg::ST_W-1:0] out_status_r;
  logic [CNT_W-1:0]        out_count_r;
  logic signed [ple_pkg::VALUE_W-1:0] out_front_r, out_back_r;

  logic                    accept;
  logic                    load_out;
  logic                    full;
  logic                    empty;
  logic [CMP_W-1:0]        pos_ext, cnt_ext, idx_ext;
  ple_pkg::cell_kind_t     kind;
  ple_pkg::cell_kind_t     cell_kind;
  ple_pkg::status_t        status;
  logic [IDX_W-1:0]        cell_idx;

  logic signed [ple_pkg::VALUE_W-1:0] cell_val [CAPACITY];
  logic signed [ple_pkg::VALUE_W-1:0] cell_tap [CAPACITY];
  logic signed [ple_pkg::VALUE_W-1:0] back_or;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = pend_r;
  assign full     = (count_r == CAP_CNT);
  assign empty    = (count_r == '0);
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);

  // Decode the operation and check it against the current fill
  always_comb begin
    kind    = ple_pkg::CK_HOLD;
    idx_ext = '0;
    status  = ple_pkg::ST_BAD;
    case (ple_pkg::op_t'(in_operation))
      ple_pkg::OP_INS_FRONT: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          status = ple_pkg::ST_DONE;
          kind   = ple_pkg::CK_INS;
        end
      end
      ple_pkg::OP_INS_BACK: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          status  = ple_pkg::ST_DONE;
          kind    = ple_pkg::CK_INS;
          idx_ext = cnt_ext;
        end
      end
      ple_pkg::OP_INS_AT: begin
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          status = ple_pkg::ST_BAD;
        end else begin
          status  = ple_pkg::ST_DONE;
          kind    = ple_pkg::CK_INS;
          idx_ext = pos_ext - CMP_W'(1);
        end
      end
      ple_pkg::OP_DEL_FRONT: begin
        if (!empty) begin
          status = ple_pkg::ST_DONE;
          kind   = ple_pkg::CK_DEL;
        end
      end
      ple_pkg::OP_DEL_BACK: begin
        if (!empty) begin
          status  = ple_pkg::ST_DONE;
          kind    = ple_pkg::CK_DEL;
          idx_ext = cnt_ext - CMP_W'(1);
        end
      end
      ple_pkg::OP_DEL_AT: begin
        if (pos_ext != '0 && pos_ext <= cnt_ext) begin
          status  = ple_pkg::ST_DONE;
          kind    = ple_pkg::CK_DEL;
          idx_ext = pos_ext - CMP_W'(1);
        end
      end
      default: status = ple_pkg::ST_BAD;
    endcase
  end

  assign cell_kind = accept ? kind : ple_pkg::CK_HOLD;
  assign cell_idx  = idx_ext[IDX_W-1:0];

  // Fill count follows the command sent to the row
  always_comb begin
    count_nxt = count_r;
    case (cell_kind)
      ple_pkg::CK_INS: count_nxt = count_r + CNT_W'(1);
      ple_pkg::CK_DEL: count_nxt = count_r - CNT_W'(1);
      default:         count_nxt = count_r;
    endcase
  end

  // Row of cells, front at place 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ple_pkg::VALUE_W-1:0] left_val, right_val;
    if (g == 0) begin : g_first
      assign left_val = in_value;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end
    ple_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .cmd_kind  (cell_kind),
      .cmd_idx   (cell_idx),
      .ins_value (in_value),
      .left_val  (left_val),
      .right_val (right_val),
      .count     (count_r),
      .val       (cell_val[g]),
      .tap       (cell_tap[g])
    );
  end

  // Back value: only the last held cell's tap is non-zero
  always_comb begin
    back_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_or = back_or | cell_tap[i];
    end
  end

  assign load_out = pend_r & (~out_valid_r | ~out_stall);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        pend_r <= 1'b1;
      end else if (load_out) begin
        pend_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= status;
    end
    if (load_out) begin
      out_status_r <= pend_status_r;
      out_count_r  <= count_r;
      out_front_r  <= empty ? '0 : cell_val[0];
      out_back_r   <= back_or;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_count       = out_count_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

endmodule

// ===== rtl/ple_checker.sv =====
module ple_checker #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEF,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ple_pkg::ST_W-1:0]            out_status,
  input logic [CNT_W-1:0]                    out_count,
  input logic signed [ple_pkg::VALUE_W-1:0]  out_front_value,
  input logic signed [ple_pkg::VALUE_W-1:0]  out_back_value
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // An accepted item keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after an item");

  // Reported fill never exceeds the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CAP_CNT))
    else $error("count above capacity");

  // A full rejection only happens with the list full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ple_pkg::ST_FULL) |-> (out_count == CAP_CNT))
    else $error("full status with room left");

  // Empty list reports zero front and back
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |->
      (out_front_value == '0 && out_back_value == '0))
    else $error("empty list with non-zero ends");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_count) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind positional_list_engine_unit ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);
